// ----- hw/rtl/cslm_pkg.sv -----
// Shared constants and codes for the strict local-minimum counter.
package cslm_pkg;

  // Configuration register fields.
  localparam int unsigned ROW_COUNT_WIDTH    = 13;
  localparam int unsigned COLUMN_COUNT_WIDTH = 11;
  localparam int unsigned CFG_DATA_WIDTH     = ROW_COUNT_WIDTH;
  localparam int unsigned CFG_INDEX_WIDTH    = 1;

  // Result field.
  localparam int unsigned TOTAL_WIDTH = 23;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_ROW_COUNT    = 1'b0,
    CFG_COLUMN_COUNT = 1'b1
  } cfg_index_e;

endpackage

// ----- hw/rtl/cslm_if.sv -----
// Channel interfaces: cell stream in, result stream out, configuration writes.
interface cslm_cell_if #(
  parameter int unsigned VALUE_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] cell_value;

  modport source (output valid, output cell_value, input ready);
  modport sink (input valid, input cell_value, output ready);
endinterface

interface cslm_total_if;
  import cslm_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [TOTAL_WIDTH-1:0] minima_total;

  modport source (output valid, output minima_total, input ready);
  modport sink (input valid, input minima_total, output ready);
endinterface

interface cslm_cfg_if;
  import cslm_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [CFG_INDEX_WIDTH-1:0] index;
  logic [CFG_DATA_WIDTH-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/cslm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module cslm_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Read returns the old contents when both ports hit the same entry.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/count_strict_local_minima_3x3_core.sv -----
// Top level of the streaming 3x3 strict local-minimum counter.
//
// Cells arrive in raster order on cell_i, one transaction per clock at full rate. A frame is
// row_count by column_count cells (a zero size acts as 1, a size above MAX_ROWS or MAX_COLUMNS
// saturates). The block counts cells strictly below every neighbor that lies inside the frame
// and, once the last cell of the frame has passed the decision stage into the result
// register, presents the count as one transaction on total_o, then starts the next frame
// from zero. The column of the incoming cell is read from the line memory when the cell is
// taken, and the window shift, write-back and minimum decisions happen on the following
// cycle. The block takes one cell per cycle; cell_i.ready drops only when a frame-ending
// cell would land on the result register while an earlier count still waits there or is
// just being loaded: for one cycle per frame when 1x1 frames stream back to back, and for
// as long as total_o stalls with a count waiting. Earlier counts may wait on total_o while
// the next frame streams in. Configuration writes are accepted every cycle, take effect at
// once and restart the frame; issue them only while the block is idle.
module count_strict_local_minima_3x3_core
  import cslm_pkg::*;
#(
  parameter int unsigned MAX_COLUMNS = 1024,
  parameter int unsigned MAX_ROWS    = 4096,
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  cslm_cell_if.sink      cell_i,
  cslm_total_if.source   total_o,
  cslm_cfg_if.sink       cfg_i
);

  localparam int unsigned ColWidth = $clog2(MAX_COLUMNS);
  localparam int unsigned RowWidth = $clog2(MAX_ROWS);
  localparam int unsigned LineWidth = 2 * VALUE_WIDTH;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef value_t win_t [9];

  // Per-cell position flags carried from acceptance to the decision stage.
  typedef struct packed {
    logic row_ge1;
    logic row_ge2;
    logic col_ge1;
    logic col_ge2;
    logic row_last;
    logic col_last;
  } pos_flags_t;

  // Strict minimum of the window entry (wr, wc) over its in-window neighbors; drop the row
  // above unless top_ok, drop the column to the left unless left_ok.
  function automatic logic strict_min(win_t win, int wr, int wc, logic top_ok,
                                      logic left_ok);
    logic is_min;
    is_min = 1'b1;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if ((i >= wr - 1) && (i <= wr + 1) && (j >= wc - 1) && (j <= wc + 1) &&
            !((i == wr) && (j == wc)) &&
            !((i == wr - 1) && !top_ok) && !((j == wc - 1) && !left_ok)) begin
          if (!(win[wr*3+wc] < win[i*3+j])) begin
            is_min = 1'b0;
          end
        end
      end
    end
    return is_min;
  endfunction

  // Configuration: last valid row and column index.
  logic [RowWidth-1:0] row_last_q, row_last_d;
  logic [ColWidth-1:0] col_last_q, col_last_d;

  // Position of the next cell and the running count.
  logic [RowWidth-1:0]    row_pos_q, row_pos_d;
  logic [ColWidth-1:0]    col_pos_q, col_pos_d;
  logic [TOTAL_WIDTH-1:0] total_q, total_d;

  // Decision stage.
  logic                s1_valid_q;
  logic                s1_end_q;
  pos_flags_t          s1_flags_q, s1_flags_d;
  logic [ColWidth-1:0] s1_col_q;
  value_t              s1_value_q;

  // Forwarding of a same-entry write-back.
  logic                 fwd_q, fwd_d;
  logic [LineWidth-1:0] fwd_data_q;

  // Window and result register.
  win_t                   win_q, win_d;
  logic                   out_valid_q, out_valid_d;
  logic [TOTAL_WIDTH-1:0] out_total_q;

  logic                   cfg_write;
  logic                   accept;
  logic                   frame_end;
  logic [31:0]            row_cfg, col_cfg;
  logic [LineWidth-1:0]   line_rdata, line_data, line_wdata;
  value_t                 upper_val, middle_val;
  logic [3:0]             hits;
  logic [2:0]             hit_count;
  logic [TOTAL_WIDTH-1:0] total_sum;
  logic                   s1_emit;

  // Configuration port.
  assign cfg_i.ready = 1'b1;
  assign cfg_write   = cfg_i.valid && cfg_i.ready;

  always_comb begin
    row_cfg = 32'(cfg_i.data[ROW_COUNT_WIDTH-1:0]);
    col_cfg = 32'(cfg_i.data[COLUMN_COUNT_WIDTH-1:0]);
    if (row_cfg == 32'd0) begin
      row_cfg = 32'd1;
    end else if (row_cfg > 32'(MAX_ROWS)) begin
      row_cfg = 32'(MAX_ROWS);
    end
    if (col_cfg == 32'd0) begin
      col_cfg = 32'd1;
    end else if (col_cfg > 32'(MAX_COLUMNS)) begin
      col_cfg = 32'(MAX_COLUMNS);
    end
  end

  always_comb begin
    row_last_d = row_last_q;
    col_last_d = col_last_q;
    if (cfg_write) begin
      unique case (cfg_index_e'(cfg_i.index))
        CFG_ROW_COUNT:    row_last_d = RowWidth'(row_cfg - 32'd1);
        CFG_COLUMN_COUNT: col_last_d = ColWidth'(col_cfg - 32'd1);
        default:          ;
      endcase
    end
  end

  // Input side: accept unless a frame-ending cell could find the result register taken.
  assign frame_end    = (row_pos_q == row_last_q) && (col_pos_q == col_last_q);
  assign cell_i.ready = !(frame_end && ((s1_valid_q && s1_end_q) ||
                                        (out_valid_q && !total_o.ready)));
  assign accept       = cell_i.valid && cell_i.ready;

  always_comb begin
    s1_flags_d.row_ge1  = row_pos_q != '0;
    s1_flags_d.row_ge2  = row_pos_q > RowWidth'(1);
    s1_flags_d.col_ge1  = col_pos_q != '0;
    s1_flags_d.col_ge2  = col_pos_q > ColWidth'(1);
    s1_flags_d.row_last = row_pos_q == row_last_q;
    s1_flags_d.col_last = col_pos_q == col_last_q;
  end

  always_comb begin
    row_pos_d = row_pos_q;
    col_pos_d = col_pos_q;
    if (cfg_write) begin
      row_pos_d = '0;
      col_pos_d = '0;
    end else if (accept) begin
      if (frame_end) begin
        row_pos_d = '0;
        col_pos_d = '0;
      end else if (col_pos_q == col_last_q) begin
        col_pos_d = '0;
        row_pos_d = row_pos_q + RowWidth'(1);
      end else begin
        col_pos_d = col_pos_q + ColWidth'(1);
      end
    end
  end

  // Line memory: upper line in the high half, middle line in the low half.
  assign fwd_d      = accept && s1_valid_q && (col_pos_q == s1_col_q);
  assign line_data  = fwd_q ? fwd_data_q : line_rdata;
  assign upper_val  = value_t'(line_data[LineWidth-1:VALUE_WIDTH]);
  assign middle_val = value_t'(line_data[VALUE_WIDTH-1:0]);
  assign line_wdata = {middle_val, s1_value_q};

  cslm_ram #(
    .Width(LineWidth),
    .Depth(MAX_COLUMNS)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (s1_valid_q),
    .waddr_i(s1_col_q),
    .wdata_i(line_wdata),
    .re_i   (accept),
    .raddr_i(col_pos_q),
    .rdata_o(line_rdata)
  );

  // Shift the window and bring in the new right column.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_d[k*3+0] = win_q[k*3+1];
      win_d[k*3+1] = win_q[k*3+2];
    end
    win_d[2] = upper_val;
    win_d[5] = middle_val;
    win_d[8] = s1_value_q;
  end

  // Decide every cell whose neighborhood is now complete.
  always_comb begin
    hits[0] = s1_flags_q.row_ge1 && s1_flags_q.col_ge1 &&
              strict_min(win_d, 1, 1, s1_flags_q.row_ge2, s1_flags_q.col_ge2);
    hits[1] = s1_flags_q.row_ge1 && s1_flags_q.col_last &&
              strict_min(win_d, 1, 2, s1_flags_q.row_ge2, s1_flags_q.col_ge1);
    hits[2] = s1_flags_q.row_last && s1_flags_q.col_ge1 &&
              strict_min(win_d, 2, 1, s1_flags_q.row_ge1, s1_flags_q.col_ge2);
    hits[3] = s1_flags_q.row_last && s1_flags_q.col_last &&
              strict_min(win_d, 2, 2, s1_flags_q.row_ge1, s1_flags_q.col_ge1);
  end

  assign hit_count = 3'(hits[0]) + 3'(hits[1]) + 3'(hits[2]) + 3'(hits[3]);
  assign total_sum = total_q + TOTAL_WIDTH'(hit_count);
  assign s1_emit   = s1_valid_q && s1_end_q;

  always_comb begin
    total_d = total_q;
    if (cfg_write) begin
      total_d = '0;
    end else if (s1_valid_q) begin
      total_d = s1_end_q ? '0 : total_sum;
    end
  end

  // Result register: load on a frame end, drop once taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_emit) begin
      out_valid_d = 1'b1;
    end else if (total_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  assign total_o.valid        = out_valid_q;
  assign total_o.minima_total = out_total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_last_q  <= '0;
      col_last_q  <= '0;
      row_pos_q   <= '0;
      col_pos_q   <= '0;
      total_q     <= '0;
      s1_valid_q  <= 1'b0;
      s1_end_q    <= 1'b0;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      row_last_q  <= row_last_d;
      col_last_q  <= col_last_d;
      row_pos_q   <= row_pos_d;
      col_pos_q   <= col_pos_d;
      total_q     <= total_d;
      s1_valid_q  <= accept;
      s1_end_q    <= accept && frame_end;
      fwd_q       <= fwd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_flags_q <= s1_flags_d;
      s1_col_q   <= col_pos_q;
      s1_value_q <= cell_i.cell_value;
    end
    if (s1_valid_q) begin
      win_q      <= win_d;
      fwd_data_q <= line_wdata;
    end
    if (s1_emit) begin
      out_total_q <= total_sum;
    end
  end

  // A frame end never lands on a result that is still held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_emit |-> (!out_valid_q || total_o.ready))
    else $error("result register overwritten");

  // Positions stay inside the configured frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_pos_q <= row_last_q) && (col_pos_q <= col_last_q))
    else $error("position outside frame");

  // A new result follows a frame-ending cell in the decision stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_emit))
    else $error("result without frame end");

  // Forwarding only covers back-to-back cells of the same column.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> $past(s1_valid_q) && s1_valid_q)
    else $error("forwarding without write-back");

endmodule

// ----- sim/count_strict_local_minima_3x3_core_test.sv -----
// Self-checking testbench for the streaming 3x3 strict local-minimum counter.
`timescale 1ns / 100ps

module count_strict_local_minima_3x3_core_test;
  import cslm_pkg::*;

  localparam int unsigned MAX_COLUMNS   = 1024;
  localparam int unsigned MAX_ROWS      = 4096;
  localparam int unsigned VALUE_WIDTH   = 16;
  localparam int unsigned RANDOM_ITEMS  = 1250;
  localparam int unsigned TALL_CELLS    = 40;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned QUIET_LIMIT   = 4000;
  localparam int unsigned SHOWN_ERRORS  = 10;

  typedef logic signed [VALUE_WIDTH-1:0] cell_t;
  typedef logic [TOTAL_WIDTH-1:0]        total_t;
  typedef logic [CFG_DATA_WIDTH-1:0]     cfg_data_t;

  // Value styles for a frame: full range, heavy ties, or mostly extremes.
  typedef enum int {
    VAL_FULL,
    VAL_TIES,
    VAL_EXTREME
  } value_style_e;

  // Mirror of the block: line memories, 3x3 window, frame position and count.
  // Every accepted cell advances the mirror; a frame-ending cell queues a total.
  class minima_scoreboard;
    logic [ROW_COUNT_WIDTH-1:0]    rows_reg;
    logic [COLUMN_COUNT_WIDTH-1:0] cols_reg;
    cell_t       upper_line [MAX_COLUMNS];
    cell_t       middle_line [MAX_COLUMNS];
    cell_t       win [9];
    int          row_pos;
    int          col_pos;
    total_t      running;
    total_t      totals_due [$];
    int unsigned errors;

    function new();
      rows_reg = 1;
      cols_reg = 1;
      foreach (upper_line[i]) upper_line[i] = '0;
      foreach (middle_line[i]) middle_line[i] = '0;
      foreach (win[i]) win[i] = '0;
      row_pos = 0;
      col_pos = 0;
      running = '0;
      errors = 0;
    endfunction

    function int frame_rows();
      int n;
      n = rows_reg;
      if (n < 1) n = 1;
      if (n > MAX_ROWS) n = MAX_ROWS;
      return n;
    endfunction

    function int frame_cols();
      int n;
      n = cols_reg;
      if (n < 1) n = 1;
      if (n > MAX_COLUMNS) n = MAX_COLUMNS;
      return n;
    endfunction

    function void note_cfg(cfg_index_e idx, cfg_data_t data);
      if (idx == CFG_ROW_COUNT) rows_reg = data[ROW_COUNT_WIDTH-1:0];
      else cols_reg = data[COLUMN_COUNT_WIDTH-1:0];
      // A size write restarts the frame.
      row_pos = 0;
      col_pos = 0;
      running = '0;
    endfunction

    // Window cell (wr, wc) sits at frame position (ar, ac); skip neighbors
    // outside the frame.
    function bit is_strict_min(int wr, int wc, int ar, int ac, int nr, int nc);
      cell_t ctr;
      ctr = win[wr*3 + wc];
      for (int dr = -1; dr <= 1; dr++) begin
        for (int dc = -1; dc <= 1; dc++) begin
          if (dr == 0 && dc == 0) continue;
          if (ar + dr < 0 || ar + dr >= nr || ac + dc < 0 || ac + dc >= nc) continue;
          if (wr + dr < 0 || wr + dr > 2 || wc + dc < 0 || wc + dc > 2) continue;
          if (!(ctr < win[(wr+dr)*3 + wc + dc])) return 0;
        end
      end
      return 1;
    endfunction

    function void note_cell(cell_t v);
      int nr, nc, r, c;
      nr = frame_rows();
      nc = frame_cols();
      r = row_pos;
      c = col_pos;
      if (r >= nr) r = nr - 1;
      if (c >= nc) c = nc - 1;
      for (int k = 0; k < 3; k++) begin
        win[k*3]     = win[k*3 + 1];
        win[k*3 + 1] = win[k*3 + 2];
      end
      win[2] = upper_line[c];
      win[5] = middle_line[c];
      win[8] = v;
      upper_line[c] = middle_line[c];
      middle_line[c] = v;
      if (r >= 1 && c >= 1 && is_strict_min(1, 1, r - 1, c - 1, nr, nc)) running++;
      if (r >= 1 && c == nc - 1 && is_strict_min(1, 2, r - 1, c, nr, nc)) running++;
      if (r == nr - 1 && c >= 1 && is_strict_min(2, 1, r, c - 1, nr, nc)) running++;
      if (r == nr - 1 && c == nc - 1 && is_strict_min(2, 2, r, c, nr, nc)) running++;
      if (r == nr - 1 && c == nc - 1) begin
        totals_due.push_back(running);
        row_pos = 0;
        col_pos = 0;
        running = '0;
        return;
      end
      c++;
      if (c >= nc) begin
        c = 0;
        r++;
      end
      row_pos = r;
      col_pos = c;
    endfunction

    function void check_total(total_t got);
      total_t want;
      if (totals_due.size() == 0) begin
        errors++;
        if (errors <= SHOWN_ERRORS)
          $display("%0t: unexpected minima_total %0d with nothing pending", $realtime, got);
        return;
      end
      want = totals_due.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= SHOWN_ERRORS)
          $display("%0t: minima_total mismatch: expected %0d, got %0d", $realtime, want, got);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  cslm_cell_if #(.VALUE_WIDTH(VALUE_WIDTH)) cell_bus ();
  cslm_total_if                             total_bus ();
  cslm_cfg_if                               cfg_bus ();

  count_strict_local_minima_3x3_core #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cell_i  (cell_bus),
    .total_o (total_bus),
    .cfg_i   (cfg_bus)
  );

  minima_scoreboard board;

  bit          calm;          // no idling on either side while set
  bit          hold_req;      // ask the receiver for one long hold-off
  bit          running_phase; // high between reset release and the end
  int unsigned random_items;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Drive every input to a known value from time zero.
  initial begin
    rst_ni              <= 1'b0;
    cell_bus.valid      <= 1'b0;
    cell_bus.cell_value <= '0;
    cfg_bus.valid       <= 1'b0;
    cfg_bus.index       <= CFG_ROW_COUNT;
    cfg_bus.data        <= '0;
    total_bus.ready     <= 1'b0;
  end

  // Receiver: check each result transaction, then decide ready for the next
  // cycle. A requested hold-off keeps ready low for HOLD_CYCLES in a row.
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    wait (running_phase);
    forever begin
      @(posedge clk_i);
      if (total_bus.valid && total_bus.ready) board.check_total(total_bus.minima_total);
      if (hold_left == 0 && hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        total_bus.ready <= 1'b0;
      end else begin
        total_bus.ready <= calm || ($urandom_range(99) >= 14);
      end
    end
  end

  // Watchdog: count cycles with no transaction on any channel.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    wait (running_phase);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((cell_bus.valid && cell_bus.ready) || (total_bus.valid && total_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("count_strict_local_minima_3x3_core_test: done, errors");
    $finish;
  end

  function automatic cell_t pick_cell(value_style_e style);
    cell_t v;
    case (style)
      VAL_TIES: begin
        v = cell_t'($urandom_range(3)) - cell_t'(1);
      end
      VAL_EXTREME: begin
        case ($urandom_range(4))
          0: v = 16'sh8000;
          1: v = 16'sh7FFF;
          2: v = 16'sh8001;
          3: v = 16'sh7FFE;
          default: v = cell_t'($urandom);
        endcase
      end
      default: begin
        v = cell_t'($urandom);
      end
    endcase
    return v;
  endfunction

  // Offer one cell, with a random idle gap first; hold valid high afterward
  // so back-to-back cells keep the bus busy.
  task automatic send_cell(input cell_t v);
    int unsigned gap;
    gap = 0;
    while (!calm && $urandom_range(99) < 14) gap++;
    if (gap > 0) begin
      cell_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cell_bus.valid      <= 1'b1;
    cell_bus.cell_value <= v;
    @(posedge clk_i);
    while (!cell_bus.ready) @(posedge clk_i);
    board.note_cell(v);
  endtask

  task automatic send_cells(input int unsigned count, input value_style_e style);
    for (int unsigned i = 0; i < count; i++) send_cell(pick_cell(style));
  endtask

  // Drop valid, wait until every expected total has arrived, then let the
  // write-back pipeline settle so the block is truly idle.
  task automatic drain();
    cell_bus.valid <= 1'b0;
    while (board.totals_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_index_e idx, input cfg_data_t data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    board.note_cfg(idx, data);
  endtask

  // Write both size registers while idle; valid stays high across the pair.
  task automatic set_sizes(input cfg_data_t rows, input cfg_data_t cols);
    drain();
    write_reg(CFG_ROW_COUNT, rows);
    write_reg(CFG_COLUMN_COUNT, cols);
    cfg_bus.valid <= 1'b0;
  endtask

  initial begin : main
    int unsigned rows, cols, frames, cells, extra;
    cfg_data_t   rows_data, cols_data;
    value_style_e style;
    bit          did_tall, did_wide, did_hold;

    board = new();
    calm = 1'b0;
    hold_req = 1'b0;
    running_phase = 1'b0;
    random_items = 0;
    did_tall = 1'b0;
    did_wide = 1'b0;
    did_hold = 1'b0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    running_phase = 1'b1;
    @(posedge clk_i);

    // Reset size is 1x1: each cell is a frame of its own and a minimum.
    send_cell(16'sh8000);
    send_cell(16'sh7FFF);

    // 2x2 all equal: ties disqualify every cell.
    set_sizes(2, 2);
    repeat (4) send_cell(16'sh0005);
    // 2x2 with the most negative value in a corner against the most positive.
    send_cell(16'sh8000);
    repeat (3) send_cell(16'sh7FFF);

    // 3x3 with a single dip in the middle, flat elsewhere.
    set_sizes(3, 3);
    repeat (4) send_cell(16'sh0000);
    send_cell(16'shFFFF);
    repeat (4) send_cell(16'sh0000);

    // Zero row count acts as one row: a 1x3 line with its middle lowest.
    set_sizes(0, 3);
    send_cell(16'sh0002);
    send_cell(16'sh0001);
    send_cell(16'sh0003);

    // Part of a frame, then a size write that drops it.
    set_sizes(2, 2);
    send_cell(16'sh0010);
    send_cell(16'sh0011);

    // Random phases: mostly small frames streamed whole, a few partial ones,
    // the top of one saturated tall frame, and one full wide frame streamed
    // with no idling on either side.
    while (random_items < RANDOM_ITEMS) begin
      if (!did_tall && random_items >= 40) begin
        // Row count beyond the maximum saturates; a column value whose set
        // bits all lie above the register width reads as zero. Stream the
        // top of this one-column frame; the next size write drops it.
        did_tall = 1'b1;
        set_sizes(13'h1FFF, 13'h0800);
        send_cells(TALL_CELLS, VAL_FULL);
        random_items += TALL_CELLS;
        continue;
      end
      if (!did_hold && random_items >= 90) begin
        // Stall the receiver for a long stretch while short frames keep
        // coming, so completed counts back up and stall the cell input.
        did_hold = 1'b1;
        set_sizes(1, 2);
        hold_req = 1'b1;
        send_cells(60, VAL_FULL);
        random_items += 60;
        continue;
      end
      if (!did_wide && random_items >= 150) begin
        did_wide = 1'b1;
        set_sizes(1, 13'h1FFF);
        calm = 1'b1;
        send_cells(MAX_COLUMNS, VAL_EXTREME);
        calm = 1'b0;
        random_items += MAX_COLUMNS;
        continue;
      end

      rows = $urandom_range(1, 6);
      cols = $urandom_range(1, 10);
      if ($urandom_range(9) == 0) begin
        rows = $urandom_range(1, 20);
        cols = $urandom_range(1, 40);
      end
      if ($urandom_range(7) == 0) begin
        rows = 1;
        cols = 1;
      end
      rows_data = cfg_data_t'(rows);
      cols_data = cfg_data_t'(cols);
      if (rows == 1 && $urandom_range(1) == 0) rows_data = '0;
      if (cols == 1 && $urandom_range(1) == 0) cols_data = '0;
      frames = $urandom_range(1, 4);
      style = value_style_e'($urandom_range(2));
      cells = rows * cols;

      set_sizes(rows_data, cols_data);
      send_cells(frames * cells, style);
      random_items += frames * cells;
      // Now and then leave a frame unfinished; the next size write drops it.
      if (cells > 1 && $urandom_range(7) == 0) begin
        extra = $urandom_range(1, cells - 1);
        send_cells(extra, style);
        random_items += extra;
      end
    end

    calm = 1'b0;
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (board.errors == 0 && board.totals_due.size() == 0)
      $display("count_strict_local_minima_3x3_core_test: done, clean");
    else
      $display("count_strict_local_minima_3x3_core_test: done, errors");
    $finish;
  end

endmodule
